>>> sv/jsu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and codes for the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned StatusW = 3;
  localparam int unsigned AccumW  = 12;
  localparam int unsigned MaxRes  = 3;

  // result status codes
  localparam logic [StatusW-1:0] ST_BYTE   = 3'd0;
  localparam logic [StatusW-1:0] ST_DONE   = 3'd1;
  localparam logic [StatusW-1:0] ST_NOOPEN = 3'd2;
  localparam logic [StatusW-1:0] ST_EOT    = 3'd3;
  localparam logic [StatusW-1:0] ST_BADESC = 3'd4;
  localparam logic [StatusW-1:0] ST_BADHEX = 3'd5;

  typedef enum logic [4:0] {
    PH_WAIT = 5'b00001,
    PH_STR  = 5'b00010,
    PH_ESC  = 5'b00100,
    PH_HEX  = 5'b01000,
    PH_IDLE = 5'b10000
  } phase_t;

  // decoder state carried between bytes
  typedef struct packed {
    phase_t             phase;
    logic [1:0]         hex_cnt;
    logic [AccumW-1:0]  accum;
  } dec_state_t;

  // results caused by one source byte; only the first can carry a non-byte status
  typedef struct packed {
    logic [1:0]         cnt;
    logic [StatusW-1:0] status;
    logic [ByteW-1:0]   b0;
    logic [ByteW-1:0]   b1;
    logic [ByteW-1:0]   b2;
  } dec_res_t;

endpackage
`default_nettype wire

>>> sv/json_string_unescape_utf8.sv
`default_nettype none
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// Decodes a JSON string literal byte by byte into unescaped UTF-8 bytes.
// ----------------------------------------------------------------------------
// results are registered: they appear in the cycle after the source byte is transferred
// throughput: one source byte per cycle while each byte gives at most one
//   result and the output is not stalled; a \u escape that gives two or three
//   bytes holds the input while the result buffer drains
// reset: synchronous active-low rst_n; decoder waits for an opening quote,
//   result buffer empty
module json_string_unescape_utf8 import jsu_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [ByteW-1:0]   in_byte,
  input  wire logic               in_start_value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [ByteW-1:0]        out_byte,
  output logic [StatusW-1:0]      out_status,
  output logic                    out_last_of_run
);

  dec_state_t         st_r, st_nxt;
  dec_res_t           res;
  logic [1:0]         cnt_r, cnt_nxt;
  logic [StatusW-1:0] status_r;
  logic [ByteW-1:0]   b0_r, b1_r, b2_r;
  logic               in_acc, out_acc;

  jsu_decode u_dec (
    .byte_i  (in_byte),
    .start_i (in_start_value),
    .state_i (st_r),
    .state_o (st_nxt),
    .res_o   (res)
  );

  assign out_acc  = out_valid && !out_stall;
  // take a new byte only when the buffer is empty or empties in this cycle
  assign in_stall = (cnt_r > 2'd1) || (cnt_r == 2'd1 && out_stall);
  assign in_acc   = in_valid && !in_stall;

  assign out_valid       = cnt_r != 2'd0;
  assign out_byte        = b0_r;
  assign out_status      = status_r;
  assign out_last_of_run = cnt_r == 2'd1;

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_acc) begin
      cnt_nxt = res.cnt;
    end else if (out_acc) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase   <= PH_WAIT;
      st_r.hex_cnt <= 2'd0;
      st_r.accum   <= '0;
      cnt_r        <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (in_acc) begin
        st_r <= st_nxt;
      end
    end
  end

  // result buffer payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      status_r <= res.status;
      b0_r     <= res.b0;
      b1_r     <= res.b1;
      b2_r     <= res.b2;
    end else if (out_acc) begin
      status_r <= ST_BYTE;
      b0_r     <= b1_r;
      b1_r     <= b2_r;
    end
  end

  a_accept_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> (cnt_r == 2'd0 || (cnt_r == 2'd1 && out_acc)))
    else $error("input transfer while results still pending");

  a_status_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_BYTE) |-> out_last_of_run)
    else $error("non-byte status not last of its run");

  a_burst_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && cnt_r > 2'd1) |=> (out_valid && out_status == ST_BYTE))
    else $error("burst continuation lost or has wrong status");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && res.cnt != 2'd0) |=> (out_valid && cnt_r == $past(res.cnt)))
    else $error("results of a transfer not loaded");

endmodule
`default_nettype wire

>>> sv/jsu_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_decode
// Per-byte decode: next state and up to three results for one source byte.
// ----------------------------------------------------------------------------
module jsu_decode import jsu_pkg::*; (
  input  wire logic [ByteW-1:0] byte_i,
  input  wire logic             start_i,
  input  wire dec_state_t       state_i,
  output dec_state_t            state_o,
  output dec_res_t              res_o
);

  logic [4:0]  hex_v;   // bit 4 flags a valid digit
  logic [15:0] cp;
  phase_t      ph;

  function automatic logic [4:0] hex_digit(input logic [ByteW-1:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, b[3:0]};
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      r = {1'b1, b[3:0] + 4'd9};
    end
    return r;
  endfunction

  assign hex_v = hex_digit(byte_i);
  assign cp    = {state_i.accum, hex_v[3:0]};
  assign ph    = start_i ? PH_WAIT : state_i.phase;

  always_comb begin
    state_o    = state_i;
    state_o.phase = ph;
    res_o      = '0;
    case (ph)
      PH_WAIT: begin
        state_o.hex_cnt = 2'd0;
        state_o.accum   = '0;
        if (byte_i == 8'h22) begin
          state_o.phase = PH_STR;
        end else begin
          res_o.cnt     = 2'd1;
          res_o.status  = ST_NOOPEN;
          state_o.phase = PH_IDLE;
        end
      end
      PH_STR: begin
        if (byte_i == 8'h00) begin
          res_o.cnt     = 2'd1;
          res_o.status  = ST_EOT;
          state_o.phase = PH_IDLE;
        end else if (byte_i == 8'h22) begin
          res_o.cnt     = 2'd1;
          res_o.status  = ST_DONE;
          state_o.phase = PH_IDLE;
        end else if (byte_i == 8'h5c) begin
          state_o.phase = PH_ESC;
        end else begin
          res_o.cnt = 2'd1;
          res_o.b0  = byte_i;
        end
      end
      PH_ESC: begin
        state_o.phase = PH_STR;
        res_o.cnt     = 2'd1;
        case (byte_i)
          8'h22, 8'h5c, 8'h2f: res_o.b0 = byte_i;
          8'h62: res_o.b0 = 8'h08;
          8'h66: res_o.b0 = 8'h0c;
          8'h6e: res_o.b0 = 8'h0a;
          8'h72: res_o.b0 = 8'h0d;
          8'h74: res_o.b0 = 8'h09;
          8'h75: begin
            res_o.cnt       = 2'd0;
            state_o.phase   = PH_HEX;
            state_o.hex_cnt = 2'd0;
            state_o.accum   = '0;
          end
          default: begin
            res_o.status  = ST_BADESC;
            state_o.phase = PH_IDLE;
          end
        endcase
      end
      PH_HEX: begin
        if (!hex_v[4]) begin
          res_o.cnt     = 2'd1;
          res_o.status  = ST_BADHEX;
          state_o.phase = PH_IDLE;
        end else if (state_i.hex_cnt != 2'd3) begin
          state_o.accum   = {state_i.accum[AccumW-5:0], hex_v[3:0]};
          state_o.hex_cnt = state_i.hex_cnt + 2'd1;
        end else begin
          // fourth digit: emit utf-8 encoding of the full code
          if (cp < 16'h0080) begin
            res_o.cnt = 2'd1;
            res_o.b0  = cp[7:0];
          end else if (cp < 16'h0800) begin
            res_o.cnt = 2'd2;
            res_o.b0  = {3'b110, cp[10:6]};
            res_o.b1  = {2'b10, cp[5:0]};
          end else begin
            res_o.cnt = 2'd3;
            res_o.b0  = {4'b1110, cp[15:12]};
            res_o.b1  = {2'b10, cp[11:6]};
            res_o.b2  = {2'b10, cp[5:0]};
          end
          state_o.hex_cnt = 2'd0;
          state_o.accum   = '0;
          state_o.phase   = PH_STR;
        end
      end
      default: begin
        state_o.phase = PH_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> sim/json_string_unescape_utf8_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_test
// Self-checking bench for the JSON string unescaper. Source bytes are fed
// from a queue of literals: a directed set first, then random well-formed
// literals with some broken ones. A behavioural decoder predicts each
// result, and the monitor compares every result transfer against it. Both
// channels idle and stall at random.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_test import jsu_pkg::*; ();

  localparam logic [7:0] QUOTE  = 8'h22;
  localparam logic [7:0] BSLASH = 8'h5c;
  localparam logic [7:0] U_CHAR = 8'h75;
  localparam int unsigned RANDOM_ITEMS = 300;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [7:0] b;
    logic       start;
  } src_item_t;

  typedef struct packed {
    logic [7:0]         b;
    logic [StatusW-1:0] status;
    logic               last;
  } dec_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [ByteW-1:0] in_byte = '0;
  logic in_start_value = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [ByteW-1:0] out_byte;
  logic [StatusW-1:0] out_status;
  logic out_last_of_run;

  src_item_t src_q[$];
  dec_out_t expected_out[$];
  int unsigned total_src = 0;
  int unsigned accepted_src = 0;
  int unsigned err_count = 0;
  int unsigned cycle_count = 0;

  // predictor state
  phase_t dec_phase = PH_WAIT;
  logic [1:0] hex_seen = '0;
  logic [AccumW-1:0] code_acc = '0;

  logic [7:0] simple_esc[8] = '{8'h22, 8'h5c, 8'h2f, 8'h62, 8'h66, 8'h6e, 8'h72, 8'h74};

  json_string_unescape_utf8 i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .in_start_value (in_start_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_status     (out_status),
    .out_last_of_run(out_last_of_run)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int hex_val(input logic [7:0] b);
    if (b >= 8'h30 && b <= 8'h39) return int'(b) - 'h30;
    if (b >= 8'h61 && b <= 8'h66) return int'(b) - 'h61 + 10;
    if (b >= 8'h41 && b <= 8'h46) return int'(b) - 'h41 + 10;
    return -1;
  endfunction

  function automatic dec_out_t mk(input logic [7:0] b, input logic [StatusW-1:0] st);
    dec_out_t r;
    r.b = b;
    r.status = st;
    r.last = 1'b0;
    return r;
  endfunction

  // advance the decoder by one source byte and queue what it gives
  task automatic predict_unescape(input src_item_t it);
    dec_out_t run[$];
    int h;
    logic [15:0] cp;
    if (it.start) dec_phase = PH_WAIT;
    case (dec_phase)
      PH_WAIT: begin
        hex_seen = '0;
        code_acc = '0;
        if (it.b == QUOTE) begin
          dec_phase = PH_STR;
        end else begin
          run.push_back(mk(8'h00, ST_NOOPEN));
          dec_phase = PH_IDLE;
        end
      end
      PH_STR: begin
        if (it.b == 8'h00) begin
          run.push_back(mk(8'h00, ST_EOT));
          dec_phase = PH_IDLE;
        end else if (it.b == QUOTE) begin
          run.push_back(mk(8'h00, ST_DONE));
          dec_phase = PH_IDLE;
        end else if (it.b == BSLASH) begin
          dec_phase = PH_ESC;
        end else begin
          run.push_back(mk(it.b, ST_BYTE));
        end
      end
      PH_ESC: begin
        dec_phase = PH_STR;
        case (it.b)
          8'h22, 8'h5c, 8'h2f: run.push_back(mk(it.b, ST_BYTE));
          8'h62: run.push_back(mk(8'h08, ST_BYTE));
          8'h66: run.push_back(mk(8'h0c, ST_BYTE));
          8'h6e: run.push_back(mk(8'h0a, ST_BYTE));
          8'h72: run.push_back(mk(8'h0d, ST_BYTE));
          8'h74: run.push_back(mk(8'h09, ST_BYTE));
          U_CHAR: begin
            dec_phase = PH_HEX;
            hex_seen = '0;
            code_acc = '0;
          end
          default: begin
            run.push_back(mk(8'h00, ST_BADESC));
            dec_phase = PH_IDLE;
          end
        endcase
      end
      PH_HEX: begin
        h = hex_val(it.b);
        if (h < 0) begin
          run.push_back(mk(8'h00, ST_BADHEX));
          dec_phase = PH_IDLE;
        end else if (hex_seen < 2'd3) begin
          code_acc = {code_acc[7:0], h[3:0]};
          hex_seen = hex_seen + 2'd1;
        end else begin
          cp = {code_acc, h[3:0]};
          if (cp < 16'h0080) begin
            run.push_back(mk(cp[7:0], ST_BYTE));
          end else if (cp < 16'h0800) begin
            run.push_back(mk({3'b110, cp[10:6]}, ST_BYTE));
            run.push_back(mk({2'b10, cp[5:0]}, ST_BYTE));
          end else begin
            run.push_back(mk({4'b1110, cp[15:12]}, ST_BYTE));
            run.push_back(mk({2'b10, cp[11:6]}, ST_BYTE));
            run.push_back(mk({2'b10, cp[5:0]}, ST_BYTE));
          end
          hex_seen = '0;
          code_acc = '0;
          dec_phase = PH_STR;
        end
      end
      default: dec_phase = PH_IDLE;
    endcase
    if (run.size() > 0) run[run.size()-1].last = 1'b1;
    foreach (run[i]) expected_out.push_back(run[i]);
  endtask

  task automatic flag_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    err_count++;
  endtask

  // ---------------- stimulus building ----------------
  int unsigned stim_n = 0;

  task automatic add_src(input logic [7:0] b, input logic s, input bit counted = 1'b1);
    src_item_t it;
    it.b = b;
    it.start = s;
    src_q.push_back(it);
    total_src++;
    if (counted) stim_n++;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return 8'h30 + {4'd0, nib};
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + {4'd0, nib} - 8'd10;
  endfunction

  task automatic add_unicode(input logic [15:0] cp);
    add_src(BSLASH, 1'b0);
    add_src(U_CHAR, 1'b0);
    add_src(hex_char(cp[15:12]), 1'b0);
    add_src(hex_char(cp[11:8]), 1'b0);
    add_src(hex_char(cp[7:4]), 1'b0);
    add_src(hex_char(cp[3:0]), 1'b0);
  endtask

  task automatic gen_literal();
    int n_el;
    int k;
    logic [7:0] b;
    logic [15:0] cp;
    if ($urandom_range(0, 11) == 0) begin
      // missing opening quote
      b = 8'($urandom_range(0, 255));
      if (b == QUOTE) b = 8'h00;
      add_src(b, 1'b1);
    end else begin
      add_src(QUOTE, 1'b1);
      n_el = $urandom_range(0, 6);
      for (int i = 0; i < n_el; i++) begin
        k = $urandom_range(0, 9);
        if (k <= 3) begin
          b = 8'($urandom_range(1, 255));
          if (b == QUOTE || b == BSLASH) b = 8'h41;
          add_src(b, 1'b0);
        end else if (k <= 5) begin
          add_src(BSLASH, 1'b0);
          add_src(simple_esc[3'($urandom_range(0, 7))], 1'b0);
        end else begin
          case ($urandom_range(0, 3))
            0: cp = 16'($urandom_range(0, 'h7f));
            1: cp = 16'($urandom_range('h80, 'h7ff));
            2: cp = 16'($urandom_range('hd800, 'hdfff));
            default: cp = 16'($urandom_range(0, 'hffff));
          endcase
          add_unicode(cp);
        end
      end
      k = $urandom_range(0, 15);
      if (k == 10) begin
        add_src(8'h00, 1'b0);
      end else if (k == 11) begin
        add_src(BSLASH, 1'b0);
        b = 8'($urandom_range(0, 255));
        if (b inside {8'h22, 8'h5c, 8'h2f, 8'h62, 8'h66, 8'h6e, 8'h72, 8'h74, U_CHAR})
          b = 8'h00;
        add_src(b, 1'b0);
      end else if (k == 12) begin
        add_src(BSLASH, 1'b0);
        add_src(U_CHAR, 1'b0);
        n_el = $urandom_range(0, 3);
        for (int i = 0; i < n_el; i++) add_src(hex_char(4'($urandom_range(0, 15))), 1'b0);
        b = 8'($urandom_range(0, 255));
        if (hex_val(b) >= 0) b = 8'h67;
        add_src(b, 1'b0);
      end else if (k == 13) begin
        // abandoned literal, next one restarts it
        return;
      end else begin
        add_src(QUOTE, 1'b0);
      end
    end
    // bytes after the end are ignored until the next start
    if ($urandom_range(0, 3) == 0) begin
      n_el = $urandom_range(1, 3);
      for (int i = 0; i < n_el; i++) add_src(8'($urandom_range(0, 255)), 1'b0, 1'b0);
    end
  endtask

  initial begin
    // directed: opening without start flag, 3-byte escape, simple escape, raw bytes
    add_src(QUOTE, 1'b0);
    add_unicode(16'hffff);
    add_src(BSLASH, 1'b0);
    add_src(8'h6e, 1'b0);
    add_src(8'hff, 1'b0);
    add_src(8'h01, 1'b0);
    add_src(QUOTE, 1'b0);
    // zero as first byte, then a byte that is ignored
    add_src(8'h00, 1'b1);
    add_src(QUOTE, 1'b0, 1'b0);
    // zero after backslash
    add_src(QUOTE, 1'b1);
    add_src(BSLASH, 1'b0);
    add_src(8'h00, 1'b0);
    // zero inside the literal
    add_src(QUOTE, 1'b1);
    add_src(8'h00, 1'b0);
    // zero in the hex digits
    add_src(QUOTE, 1'b1);
    add_src(BSLASH, 1'b0);
    add_src(U_CHAR, 1'b0);
    add_src(8'h30, 1'b0);
    add_src(8'h00, 1'b0);
    stim_n = 0;
    while (stim_n < RANDOM_ITEMS) gen_literal();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_src != total_src) @(posedge clk);
    while (expected_out.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && expected_out.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // ---------------- driver ----------------
  int unsigned drv_gap = 0;
  int unsigned drv_burst = 0;
  src_item_t drv_cur;

  always @(posedge clk) begin : drive_proc
    logic v;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      v = in_valid;
      if (in_valid && !in_stall) begin
        predict_unescape(drv_cur);
        accepted_src++;
        v = 1'b0;
        if (drv_burst > 0) begin
          drv_burst--;
          drv_gap = 0;
        end else if ($urandom_range(0, 7) == 0) begin
          drv_burst = $urandom_range(10, 30);
          drv_gap = 0;
        end else begin
          drv_gap = $urandom_range(0, 5);
        end
      end
      if (!v) begin
        if (drv_gap > 0) begin
          drv_gap--;
        end else if (src_q.size() > 0) begin
          drv_cur = src_q.pop_front();
          in_byte <= drv_cur.b;
          in_start_value <= drv_cur.start;
          v = 1'b1;
        end
      end
      in_valid <= v;
    end
  end

  // ---------------- monitor ----------------
  int unsigned mon_hold = 0;
  int unsigned mon_burst = 0;

  always @(posedge clk) begin : monitor_proc
    dec_out_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_out.size() == 0) begin
          flag_mismatch($sformatf("unexpected result byte %02h status %0d",
                                  out_byte, out_status));
        end else begin
          e = expected_out.pop_front();
          if (out_byte !== e.b)
            flag_mismatch($sformatf("out_byte %02h, want %02h", out_byte, e.b));
          if (out_status !== e.status)
            flag_mismatch($sformatf("out_status %0d, want %0d", out_status, e.status));
          if (out_last_of_run !== e.last)
            flag_mismatch($sformatf("out_last_of_run %0b, want %0b",
                                    out_last_of_run, e.last));
        end
        if (mon_burst > 0) begin
          mon_burst--;
          mon_hold = 0;
        end else if ($urandom_range(0, 7) == 0) begin
          mon_burst = $urandom_range(10, 30);
          mon_hold = 0;
        end else begin
          mon_hold = $urandom_range(0, 5);
        end
      end else if (mon_hold > 0) begin
        mon_hold--;
      end
      out_stall <= (mon_hold != 0);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule
`default_nettype wire

>>> sim.f
sv/jsu_pkg.sv
sv/jsu_decode.sv
sv/json_string_unescape_utf8.sv
sim/json_string_unescape_utf8_test.sv
